>>> hw/rtl/acrc_pkg.sv
// Shared types and constants for the associative cache replacement classifier.
`timescale 1ns / 1ps

package acrc_pkg;

  localparam int DEF_ENTRIES   = 16;
  localparam int DEF_ADDR_BITS = 16;

  localparam int ADDR_W     = 16;
  localparam int CNT_W      = 32;
  localparam int ACTIVE_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'd1;

  typedef enum logic [1:0] {
    OUT_HIT        = 2'd0,
    OUT_COMPULSORY = 2'd1,
    OUT_CAPACITY   = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

>>> hw/rtl/acrc_ctrl.sv
// Sequencer for the classifier: map clear, lookup, update and result handshake.
`timescale 1ns / 1ps

module acrc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  acrc_pkg::sts_t sts,
  output acrc_pkg::cmd_t cmd
);

  acrc_pkg::state_t state, state_next;
  logic             out_valid_next;
  logic             commit;
  logic             ready;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= acrc_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    commit     = (state == acrc_pkg::ST_UPDATE) && (!out_valid || !out_stall);
    ready      = (state == acrc_pkg::ST_IDLE) || commit;
    accept     = in_valid && ready;
    in_stall   = !ready;
    state_next = state;
    cmd        = '0;
    cmd.load   = accept;
    cmd.commit = commit;
    unique case (state)
      acrc_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = acrc_pkg::ST_IDLE;
        end
      end
      acrc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = acrc_pkg::ST_LOOKUP;
        end
      end
      acrc_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = acrc_pkg::ST_UPDATE;
      end
      acrc_pkg::ST_UPDATE: begin
        if (commit) begin
          state_next = accept ? acrc_pkg::ST_LOOKUP : acrc_pkg::ST_IDLE;
        end
      end
      default: state_next = acrc_pkg::ST_CLEAR;
    endcase
    out_valid_next = commit ? 1'b1 : (out_valid && out_stall);
  end

endmodule

>>> hw/rtl/acrc_datapath.sv
// Line list, tag compare, seen bitmap, counters and result registers.
`timescale 1ns / 1ps

module acrc_datapath #(
  parameter int ENTRIES   = acrc_pkg::DEF_ENTRIES,
  parameter int ADDR_BITS = acrc_pkg::DEF_ADDR_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  acrc_pkg::cmd_t                  cmd,
  output acrc_pkg::sts_t                  sts,
  input  logic                            cfg_we,
  input  logic [acrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acrc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [acrc_pkg::ADDR_W-1:0]     access_address,
  output logic [1:0]                      outcome,
  output logic                            evict_valid,
  output logic [acrc_pkg::ADDR_W-1:0]     evicted_address,
  output logic [acrc_pkg::CNT_W-1:0]      access_total,
  output logic [acrc_pkg::CNT_W-1:0]      miss_total,
  output logic [acrc_pkg::CNT_W-1:0]      compulsory_total,
  output logic [acrc_pkg::CNT_W-1:0]      capacity_total
);

  localparam int CW        = $clog2(ENTRIES + 1);
  localparam int MAP_DEPTH = 2 ** ADDR_BITS;

  logic                           policy_mode;
  logic [acrc_pkg::ACTIVE_W-1:0]  active_entries;

  logic [ADDR_BITS-1:0] tags [ENTRIES];
  logic [ADDR_BITS-1:0] nbr  [ENTRIES];
  logic [CW-1:0]        fill_count, fill_eff, n_eff;
  logic [ADDR_BITS-1:0] addr_q;
  logic [ENTRIES-1:0]   match, match_q, prefix, shift;
  logic                 hit, full, fill_slot, evict;

  logic                 seen_mem [MAP_DEPTH];
  logic                 seen_q;
  logic [ADDR_BITS-1:0] clr_addr;
  logic                 mem_we, mem_wd;
  logic [ADDR_BITS-1:0] mem_wa;

  acrc_pkg::outcome_t   res_outcome;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode    <= acrc_pkg::POLICY_LRU;
      active_entries <= acrc_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acrc_pkg::CFG_POLICY: policy_mode    <= cfg_data[0];
        acrc_pkg::CFG_ACTIVE: active_entries <= cfg_data[acrc_pkg::ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (active_entries == '0) begin
      n_eff = CW'(1);
    end else if (int'(active_entries) > ENTRIES) begin
      n_eff = CW'(ENTRIES);
    end else begin
      n_eff = CW'(active_entries);
    end
    fill_eff = (fill_count > n_eff) ? n_eff : fill_count;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_nbr
    if (g == ENTRIES - 1) begin : g_last
      assign nbr[g] = addr_q;
    end else begin : g_mid
      assign nbr[g] = tags[g + 1];
    end
    assign match[g] = (tags[g] == addr_q) && (g < int'(fill_eff));
  end

  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      acc       = acc | match_q[i];
      prefix[i] = acc;
    end
    hit       = acc;
    full      = (fill_count == n_eff);
    fill_slot = !hit && !full;
    evict     = !hit && full;
    if (hit && policy_mode == acrc_pkg::POLICY_LRU) begin
      shift = prefix;
    end else if (evict) begin
      shift = '1;
    end else begin
      shift = '0;
    end
    if (hit) begin
      res_outcome = acrc_pkg::OUT_HIT;
    end else if (seen_q) begin
      res_outcome = acrc_pkg::OUT_CAPACITY;
    end else begin
      res_outcome = acrc_pkg::OUT_COMPULSORY;
    end
  end

  // address capture, compare result and clamped fill
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= ADDR_BITS'(access_address);
    end
    if (cmd.lookup) begin
      match_q <= match;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.lookup) begin
      fill_count <= fill_eff;
    end else if (cmd.commit && fill_slot) begin
      fill_count <= fill_count + CW'(1);
    end
  end

  // line list, oldest at index zero
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (shift[i] && (i + 1 < int'(fill_count))) begin
          tags[i] <= nbr[i];
        end else if (shift[i] && (i + 1 == int'(fill_count))) begin
          tags[i] <= addr_q;
        end else if (fill_slot && (i == int'(fill_count))) begin
          tags[i] <= addr_q;
        end
      end
    end
  end

  // seen bitmap: cleared after reset, set on eviction
  assign mem_we          = cmd.clear_step || (cmd.commit && evict);
  assign mem_wa          = cmd.clear_step ? clr_addr : tags[0];
  assign mem_wd          = !cmd.clear_step;
  assign sts.clear_last  = (clr_addr == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_mem[mem_wa] <= mem_wd;
    end
    if (cmd.lookup) begin
      seen_q <= seen_mem[addr_q];
    end
  end

  // saturating counters
  always_ff @(posedge clk) begin
    if (rst) begin
      access_total     <= '0;
      miss_total       <= '0;
      compulsory_total <= '0;
      capacity_total   <= '0;
    end else if (cmd.commit) begin
      if (access_total != '1) begin
        access_total <= access_total + 32'd1;
      end
      if (!hit && miss_total != '1) begin
        miss_total <= miss_total + 32'd1;
      end
      if (res_outcome == acrc_pkg::OUT_COMPULSORY && compulsory_total != '1) begin
        compulsory_total <= compulsory_total + 32'd1;
      end
      if (res_outcome == acrc_pkg::OUT_CAPACITY && capacity_total != '1) begin
        capacity_total <= capacity_total + 32'd1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      outcome         <= res_outcome;
      evict_valid     <= evict;
      evicted_address <= evict ? acrc_pkg::ADDR_W'(tags[0]) : '0;
    end
  end

endmodule

>>> hw/rtl/assoc_cache_replacement_classifier.sv
// Top level of the fully associative cache replacement classifier (LRU / FIFO).
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_stall  access_address
//   result    out        out_valid/out_stall  outcome, evict_valid, evicted_address,
//                                             access/miss/compulsory/capacity totals
//   config    in         cfg_we               cfg_index, cfg_data
//
// A request passes a lookup step, which compares the address against every line
// in parallel and reads the seen bitmap, and then an update step, which updates
// the line list, the bitmap and the counters. The next request is taken in the
// update cycle. After reset the seen bitmap is cleared one bit a cycle, all
// 2**ADDR_BITS bits (65536 at the default), with in_stall held high.
// A result waits in the output register; while it is stalled the following
// request finishes its lookup and then holds in update until the slot frees.
`timescale 1ns / 1ps

module assoc_cache_replacement_classifier #(
  parameter int ENTRIES   = acrc_pkg::DEF_ENTRIES,
  parameter int ADDR_BITS = acrc_pkg::DEF_ADDR_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [acrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acrc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [acrc_pkg::ADDR_W-1:0]     access_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      outcome,
  output logic                            evict_valid,
  output logic [acrc_pkg::ADDR_W-1:0]     evicted_address,
  output logic [acrc_pkg::CNT_W-1:0]      access_total,
  output logic [acrc_pkg::CNT_W-1:0]      miss_total,
  output logic [acrc_pkg::CNT_W-1:0]      compulsory_total,
  output logic [acrc_pkg::CNT_W-1:0]      capacity_total
);

  acrc_pkg::cmd_t cmd;
  acrc_pkg::sts_t sts;

  // sequencer: owns the state and both handshakes
  acrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: line list, bitmap memory, counters, result registers
  acrc_datapath #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .access_address   (access_address),
    .outcome          (outcome),
    .evict_valid      (evict_valid),
    .evicted_address  (evicted_address),
    .access_total     (access_total),
    .miss_total       (miss_total),
    .compulsory_total (compulsory_total),
    .capacity_total   (capacity_total)
  );

  // a fresh result comes from a request taken before its lookup and update states
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result appeared without a request three cycles earlier");

  // no request is taken while the bitmap is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> in_stall)
    else $error("request accepted during bitmap clear");

  // an eviction only comes with a miss
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evict_valid) |-> (outcome != acrc_pkg::OUT_HIT))
    else $error("eviction reported on a hit");

  // the update step never runs alongside the clear pass or a lookup
  a_commit_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !cmd.clear_step && !cmd.lookup)
    else $error("update overlaps clear or lookup");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the associative cache replacement classifier.
`timescale 1ns / 1ps

module testbench;
  import acrc_pkg::*;

  localparam int LINES          = DEF_ENTRIES;
  localparam int PHASES         = 10;
  localparam int PHASE_REQUESTS = 113;
  localparam int HOLD_CYCLES    = 120;
  // Clearing the seen bitmap alone covers all 65536 addresses; the rest is margin.
  localparam int LIMIT_CYCLES   = 500_000;

  // One expected result per accepted request.
  typedef struct {
    outcome_t         outcome;
    logic             evict_valid;
    logic [ADDR_W-1:0] evicted_address;
    logic [CNT_W-1:0] access_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] compulsory_total;
    logic [CNT_W-1:0] capacity_total;
  } access_verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ADDR_W-1:0]     access_address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            outcome;
  logic                  evict_valid;
  logic [ADDR_W-1:0]     evicted_address;
  logic [CNT_W-1:0]      access_total;
  logic [CNT_W-1:0]      miss_total;
  logic [CNT_W-1:0]      compulsory_total;
  logic [CNT_W-1:0]      capacity_total;

  assoc_cache_replacement_classifier DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .access_address   (access_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .outcome          (outcome),
    .evict_valid      (evict_valid),
    .evicted_address  (evicted_address),
    .access_total     (access_total),
    .miss_total       (miss_total),
    .compulsory_total (compulsory_total),
    .capacity_total   (capacity_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cache mirror: line list oldest first, the seen bitmap, running totals and a
  // copy of both configuration registers.
  // ---------------------------------------------------------------------------
  logic                policy_sel = POLICY_LRU;
  logic [ACTIVE_W-1:0] active_setting = ACTIVE_RESET;
  logic [ADDR_W-1:0]   line_list [LINES];
  int                  lines_filled = 0;
  bit                  evicted_once [2**ADDR_W];
  logic [CNT_W-1:0]    accesses_seen = '0;
  logic [CNT_W-1:0]    misses_seen = '0;
  logic [CNT_W-1:0]    compulsory_seen = '0;
  logic [CNT_W-1:0]    capacity_seen = '0;

  function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the mirror by one access and return the result it must produce.
  function automatic access_verdict_t classify_access(logic [ADDR_W-1:0] addr);
    access_verdict_t v;
    int              usable;
    int              slot;
    bit              found;
    v.outcome         = OUT_HIT;
    v.evict_valid     = 1'b0;
    v.evicted_address = '0;
    // Out-of-range settings clamp to 1 .. LINES.
    usable = (active_setting == 0) ? 1 :
             (active_setting > LINES) ? LINES : int'(active_setting);
    // A lowered line count drops the newest lines, unmarked.
    if (lines_filled > usable) lines_filled = usable;
    accesses_seen = sat_bump(accesses_seen);
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < lines_filled; i++) begin
      if (!found && line_list[i] == addr) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      // LRU: move the hit line to the newest end; FIFO: leave order alone.
      if (policy_sel == POLICY_LRU) begin
        for (int i = slot; i + 1 < lines_filled; i++) line_list[i] = line_list[i + 1];
        line_list[lines_filled - 1] = addr;
      end
    end else begin
      misses_seen = sat_bump(misses_seen);
      if (evicted_once[addr]) begin
        v.outcome     = OUT_CAPACITY;
        capacity_seen = sat_bump(capacity_seen);
      end else begin
        v.outcome       = OUT_COMPULSORY;
        compulsory_seen = sat_bump(compulsory_seen);
      end
      if (lines_filled < usable) begin
        line_list[lines_filled] = addr;
        lines_filled++;
      end else begin
        // Full: evict the oldest line, mark it, append the new address.
        v.evict_valid     = 1'b1;
        v.evicted_address = line_list[0];
        evicted_once[line_list[0]] = 1'b1;
        for (int i = 0; i + 1 < lines_filled; i++) line_list[i] = line_list[i + 1];
        line_list[lines_filled - 1] = addr;
      end
    end
    v.access_total     = accesses_seen;
    v.miss_total       = misses_seen;
    v.compulsory_total = compulsory_seen;
    v.capacity_total   = capacity_seen;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between stimulus, driver, receiver and checker.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] address_backlog [$];   // requests not yet offered
  access_verdict_t   awaited_results [$];   // expectations, oldest first
  int                requests_queued = 0;
  int                requests_taken = 0;
  int                fail_count = 0;
  logic              req_taken = 1'b0;      // request handshake at the last rising edge
  bit                quiet = 1'b0;          // no idling on either side
  bit                hold_asked = 1'b0;
  bit                hold_given = 1'b0;

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge. Hold valid and the
  // address until the handshake completes, then advance or idle for a burst.
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!quiet && address_backlog.size() > 0 && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 8) - 1;
        in_valid <= 1'b0;
      end else if (address_backlog.size() > 0) begin
        in_valid       <= 1'b1;
        access_address <= address_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall in random bursts, plus one long hold-off on request
  // so the block fills up and pushes back on its input.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_asked && !hold_given) begin
        hold_given = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: sample both handshakes on the rising edge. Compare results first,
  // then predict the request taken at this edge.
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    access_verdict_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("outcome", CNT_W'(want.outcome), CNT_W'(outcome));
          compare_field("evict_valid", CNT_W'(want.evict_valid), CNT_W'(evict_valid));
          compare_field("evicted_address", CNT_W'(want.evicted_address),
                        CNT_W'(evicted_address));
          compare_field("access_total", want.access_total, access_total);
          compare_field("miss_total", want.miss_total, miss_total);
          compare_field("compulsory_total", want.compulsory_total, compulsory_total);
          compare_field("capacity_total", want.capacity_total, capacity_total);
        end
      end
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        awaited_results.insert(awaited_results.size(), classify_access(access_address));
        requests_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing.
  // ---------------------------------------------------------------------------
  task automatic queue_access(logic [ADDR_W-1:0] addr);
    address_backlog.insert(address_backlog.size(), addr);
    requests_queued++;
  endtask

  // Hold until every request is taken and every result checked, then let the
  // pipeline settle before touching the registers.
  task automatic wait_drained();
    while (requests_taken != requests_queued || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register and mirror it; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) policy_sel = value[0];
    else active_setting = value;
  endtask

  // Line counts per random phase: both extremes, zero and values past the top.
  logic [ACTIVE_W-1:0] phase_active [PHASES] = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31,
                                                 5'd8, 5'd2, 5'd12, 5'd17, 5'd6};

  initial begin
    logic [ADDR_W-1:0] hot_set [40];
    int                usable;
    int                hot_count;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    // Let the bitmap clear finish before the first register write.
    repeat (2) @(posedge clk);
    while (in_stall) @(posedge clk);

    // Directed: two LRU lines, extremes of the address, hit reorder, evictions
    // and capacity misses on previously evicted addresses.
    write_reg(CFG_POLICY, 5'(POLICY_LRU));
    write_reg(CFG_ACTIVE, 5'd2);
    queue_access(16'h0000);
    queue_access(16'hFFFF);
    queue_access(16'h0000);
    queue_access(16'h1234);
    queue_access(16'hFFFF);
    queue_access(16'h0000);
    queue_access(16'h5555);
    queue_access(16'hAAAA);
    wait_drained();

    // Zero lines acts as one; switching to FIFO keeps the existing order.
    write_reg(CFG_POLICY, 5'(POLICY_FIFO));
    write_reg(CFG_ACTIVE, 5'd0);
    queue_access(16'hAAAA);
    queue_access(16'h5555);
    queue_access(16'h5555);
    queue_access(16'h0001);
    wait_drained();

    // Count past the top clamps to the full cache; FIFO hits leave order as is.
    write_reg(CFG_ACTIVE, 5'd31);
    queue_access(16'h8000);
    queue_access(16'h0001);
    queue_access(16'h8000);
    queue_access(16'h7FFF);
    queue_access(16'h0000);
    wait_drained();

    // Fill under LRU, then lower the count so the newest lines drop unmarked.
    write_reg(CFG_POLICY, 5'(POLICY_LRU));
    write_reg(CFG_ACTIVE, 5'd16);
    for (int i = 0; i < 6; i++) queue_access(16'h0100 + 16'(i));
    wait_drained();
    write_reg(CFG_ACTIVE, 5'd3);
    queue_access(16'h0105);
    queue_access(16'h0100);
    queue_access(16'h0200);
    wait_drained();

    // Random phases: mostly accesses drawn from a hot set a bit larger than
    // the cache so hits, evictions and capacity misses all recur, plus some
    // scattered addresses over the full range.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_POLICY, 5'(ph % 2 == 0 ? POLICY_LRU : POLICY_FIFO));
      write_reg(CFG_ACTIVE, phase_active[ph]);
      usable = (phase_active[ph] == 0) ? 1 :
               (phase_active[ph] > LINES) ? LINES : int'(phase_active[ph]);
      hot_count = usable + $urandom_range(1, usable + 3);
      for (int i = 0; i < hot_count; i++) hot_set[i] = ADDR_W'($urandom);
      // Quiet tail: no idling on either side for the last phase.
      quiet = (ph == PHASES - 1);
      if (ph == 0) hold_asked = 1'b1;
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        if ($urandom_range(0, 99) < 85)
          queue_access(hot_set[$urandom_range(0, hot_count - 1)]);
        else
          queue_access(ADDR_W'($urandom));
      end
      wait_drained();
    end

    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: the run is far shorter than this when the block keeps moving.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule
